// ===== rtl/core/cbct_pkg.sv =====
// Shared types, constants and helper functions of the color blob centroid tracker.
package cbct_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int CH_W   = 8;
	localparam int POS_W  = 10;
	localparam int SUM_W  = 30;
	localparam int HITS_W = 21;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int MAX_ROWS_DEF = 1024;
	localparam int MAX_COLS_DEF = 1024;

	localparam logic [CH_W-1:0] HEAD_RED_RST   = 8'd230;
	localparam logic [CH_W-1:0] HEAD_GREEN_RST = 8'd230;
	localparam logic [CH_W-1:0] HEAD_BLUE_RST  = 8'd90;
	localparam logic [CH_W-1:0] TAIL_RED_RST   = 8'd88;
	localparam logic [CH_W-1:0] TAIL_GREEN_RST = 8'd130;
	localparam logic [CH_W-1:0] TAIL_BLUE_RST  = 8'd190;
	localparam logic [CH_W-1:0] TOL_RST        = 8'd40;

	localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};
	localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};

	typedef enum logic [2:0] {
		REG_HEAD_RED   = 3'd0,
		REG_HEAD_GREEN = 3'd1,
		REG_HEAD_BLUE  = 3'd2,
		REG_TAIL_RED   = 3'd3,
		REG_TAIL_GREEN = 3'd4,
		REG_TAIL_BLUE  = 3'd5,
		REG_TOL        = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic [CH_W-1:0] head_red;
		logic [CH_W-1:0] head_green;
		logic [CH_W-1:0] head_blue;
		logic [CH_W-1:0] tail_red;
		logic [CH_W-1:0] tail_green;
		logic [CH_W-1:0] tail_blue;
		logic [CH_W-1:0] color_tolerance;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]  pix_blue;
		logic [CH_W-1:0]  pix_green;
		logic [CH_W-1:0]  pix_red;
		logic [POS_W-1:0] pix_row;
		logic [POS_W-1:0] pix_col;
		logic             frame_end;
	} pix_in_t;

	typedef struct packed {
		logic [POS_W-1:0] head_row;
		logic [POS_W-1:0] head_col;
		logic [POS_W-1:0] tail_row;
		logic [POS_W-1:0] tail_col;
		logic [POS_W-1:0] mid_row;
		logic [POS_W-1:0] mid_col;
	} result_t;

	// classified request passed from front to back
	typedef struct packed {
		logic             hit_head;
		logic             hit_tail;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} qent_t;

	// |c - t| < tol, i.e. t - tol < c < t + tol on signed values
	function automatic logic ch_near(logic [CH_W-1:0] c, logic [CH_W-1:0] t,
		logic [CH_W-1:0] tol);
		logic [CH_W:0] d;
		if (c >= t) begin
			d = {1'b0, c} - {1'b0, t};
		end else begin
			d = {1'b0, t} - {1'b0, c};
		end
		return d < {1'b0, tol};
	endfunction

	function automatic logic in_box(pix_in_t p, logic [CH_W-1:0] tr, logic [CH_W-1:0] tg,
		logic [CH_W-1:0] tb, logic [CH_W-1:0] tol);
		return ch_near(p.pix_red, tr, tol) && ch_near(p.pix_green, tg, tol) &&
			ch_near(p.pix_blue, tb, tol);
	endfunction

	function automatic logic [POS_W-1:0] sat_pos(logic [SUM_W-1:0] q);
		if (|q[SUM_W-1:POS_W]) begin
			return POS_MAX;
		end
		return q[POS_W-1:0];
	endfunction

endpackage

// ===== rtl/core/cbct_front.sv =====
// Front part: pixel intake, color box classification, index clamp and request queue.
module cbct_front #(
	parameter int MAX_ROWS = cbct_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = cbct_pkg::MAX_COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cbct_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  cbct_pkg::pix_in_t in_data,
	output logic              q_valid,
	input  logic              q_ready,
	output cbct_pkg::qent_t   q_data
);
	import cbct_pkg::*;

	localparam logic [12:0] RowLim = 13'(MAX_ROWS);
	localparam logic [12:0] ColLim = 13'(MAX_COLS);

	qent_t             fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	qent_t             ent;
	logic              push;
	logic              pop;

	always_comb begin
		ent.hit_head = in_box(in_data, cfg.head_red, cfg.head_green, cfg.head_blue,
			cfg.color_tolerance);
		ent.hit_tail = in_box(in_data, cfg.tail_red, cfg.tail_green, cfg.tail_blue,
			cfg.color_tolerance);
		ent.row  = ({3'b000, in_data.pix_row} >= RowLim) ? POS_W'(MAX_ROWS - 1) :
			in_data.pix_row;
		ent.col  = ({3'b000, in_data.pix_col} >= ColLim) ? POS_W'(MAX_COLS - 1) :
			in_data.pix_col;
		ent.last = in_data.frame_end;
	end

	assign in_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_data   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QDEPTH))
		else $error("queue count above depth");
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != (QPTR_W+1)'(QDEPTH)) |-> (wr_ptr_q - rd_ptr_q == count_q[QPTR_W-1:0]))
		else $error("queue pointers out of step with count");
`endif

endmodule

// ===== rtl/core/cbct_back.sv =====
// Back part: blob accumulators, shared serial divider and result register.
module cbct_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  cbct_pkg::qent_t   q_data,
	output logic              out_valid,
	input  logic              out_ready,
	output cbct_pkg::result_t out_data
);
	import cbct_pkg::*;

	localparam logic [STEP_W-1:0] StepLast = STEP_W'(SUM_W - 1);

	bk_state_t state_q;
	bk_state_t state_n;

	logic [SUM_W-1:0]  head_row_sum_q, head_col_sum_q, tail_row_sum_q, tail_col_sum_q;
	logic [HITS_W-1:0] head_hits_q, tail_hits_q;
	logic [SUM_W-1:0]  hrs_n, hcs_n, trs_n, tcs_n;
	logic [HITS_W-1:0] hh_n, th_n;

	// frame snapshot for the divider
	logic [SUM_W-1:0]  snap_hcs_q, snap_trs_q, snap_tcs_q;
	logic [HITS_W-1:0] snap_hh_q, snap_th_q;

	logic [SUM_W-1:0]  dvd_q;
	logic [HITS_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        pass_q;
	logic [POS_W-1:0]  res_q [4];

	logic [HITS_W-1:0] divisor;
	logic [HITS_W:0]   shifted;
	logic [HITS_W+1:0] diff;
	logic              qbit;
	logic [HITS_W-1:0] rem_n;
	logic [SUM_W-1:0]  dvd_n;
	logic [SUM_W-1:0]  next_dvd;

	logic              pop;
	logic              frame_pop;
	logic              step_done;
	logic              load_out;
	logic              out_valid_q;
	result_t           out_data_q;
	result_t           res;

	assign q_ready   = !q_data.last || (state_q == BK_IDLE);
	assign pop       = q_valid && q_ready;
	assign frame_pop = pop && q_data.last;
	assign step_done = (state_q == BK_DIV) && (step_q == StepLast);
	assign load_out  = (state_q == BK_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		hrs_n = head_row_sum_q;
		hcs_n = head_col_sum_q;
		hh_n  = head_hits_q;
		trs_n = tail_row_sum_q;
		tcs_n = tail_col_sum_q;
		th_n  = tail_hits_q;
		if (q_data.hit_head) begin
			hrs_n = head_row_sum_q + SUM_W'(q_data.row);
			hcs_n = head_col_sum_q + SUM_W'(q_data.col);
			if (head_hits_q != HITS_MAX) begin
				hh_n = head_hits_q + 1'b1;
			end
		end
		if (q_data.hit_tail) begin
			trs_n = tail_row_sum_q + SUM_W'(q_data.row);
			tcs_n = tail_col_sum_q + SUM_W'(q_data.col);
			if (tail_hits_q != HITS_MAX) begin
				th_n = tail_hits_q + 1'b1;
			end
		end
	end

	// one restoring step per cycle; quotient bits shift into the dividend register
	always_comb begin
		divisor = pass_q[1] ? snap_th_q : snap_hh_q;
		shifted = {rem_q, dvd_q[SUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, divisor};
		qbit    = !diff[HITS_W+1];
		rem_n   = qbit ? diff[HITS_W-1:0] : shifted[HITS_W-1:0];
		dvd_n   = {dvd_q[SUM_W-2:0], qbit};
		case (pass_q)
			2'd0:    next_dvd = snap_hcs_q;
			2'd1:    next_dvd = snap_trs_q;
			2'd2:    next_dvd = snap_tcs_q;
			default: next_dvd = snap_tcs_q;
		endcase
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (frame_pop) begin
					state_n = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_done && (pass_q == 2'd3)) begin
					state_n = BK_DONE;
				end
			end
			BK_DONE: begin
				if (load_out) begin
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_row_sum_q <= '0;
			head_col_sum_q <= '0;
			head_hits_q    <= HITS_W'(1);
			tail_row_sum_q <= '0;
			tail_col_sum_q <= '0;
			tail_hits_q    <= HITS_W'(1);
			step_q         <= '0;
			pass_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				if (q_data.last) begin
					head_row_sum_q <= '0;
					head_col_sum_q <= '0;
					head_hits_q    <= HITS_W'(1);
					tail_row_sum_q <= '0;
					tail_col_sum_q <= '0;
					tail_hits_q    <= HITS_W'(1);
				end else begin
					head_row_sum_q <= hrs_n;
					head_col_sum_q <= hcs_n;
					head_hits_q    <= hh_n;
					tail_row_sum_q <= trs_n;
					tail_col_sum_q <= tcs_n;
					tail_hits_q    <= th_n;
				end
			end
			if (frame_pop) begin
				step_q <= '0;
				pass_q <= '0;
			end else if (state_q == BK_DIV) begin
				if (step_done) begin
					step_q <= '0;
					pass_q <= pass_q + 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_pop) begin
			snap_hcs_q <= hcs_n;
			snap_trs_q <= trs_n;
			snap_tcs_q <= tcs_n;
			snap_hh_q  <= hh_n;
			snap_th_q  <= th_n;
			dvd_q      <= hrs_n;
			rem_q      <= '0;
		end else if (state_q == BK_DIV) begin
			if (step_done) begin
				res_q[pass_q] <= sat_pos(dvd_n);
				dvd_q         <= next_dvd;
				rem_q         <= '0;
			end else begin
				dvd_q <= dvd_n;
				rem_q <= rem_n;
			end
		end
		if (load_out) begin
			out_data_q <= res;
		end
	end

	always_comb begin
		res.head_row = res_q[0];
		res.head_col = res_q[1];
		res.tail_row = res_q[2];
		res.tail_col = res_q[3];
		res.mid_row  = POS_W'(({1'b0, res_q[0]} + {1'b0, res_q[2]}) >> 1);
		res.mid_col  = POS_W'(({1'b0, res_q[1]} + {1'b0, res_q[3]}) >> 1);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef ASSERT_OFF
	a_hits_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(head_hits_q != '0) && (tail_hits_q != '0))
		else $error("hit count reached zero");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (rem_q < divisor))
		else $error("divider remainder not below divisor");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= StepLast)
		else $error("divider step counter overran");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("result loaded without valid");
`endif

endmodule

// ===== rtl/core/color_blob_centroid_tracker_unit.sv =====
// Top level of the color blob centroid tracker: register file and front/back parts.
//
// Usage:
//   Pixel requests enter on in_valid/in_ready/in_data, one BGR pixel with its row,
//   column and frame_end mark. Each is tested against the head and tail color
//   boxes and queued (4 deep) for the accumulators.
//   One result request leaves on out_valid/out_ready/out_data per frame, at the
//   pixel marked frame_end: both blob centroids and their midpoint.
//   Registers (color targets and tolerance) sit on the APB port at 4*index;
//   change them only while the block is idle.
// Timing:
//   Pixels without frame_end are taken one per cycle while the queue has room.
//   A frame_end pixel starts the shared serial divider: four 30-bit quotients at
//   one bit per cycle; the results then go to the output register, raising out_valid.
//   The next frame's pixels keep flowing meanwhile; a second frame_end waits
//   until the divider is free, so frames shorter than a division run stall.
// Reset: arst_n clears the queue, accumulators (sums 0, counts 1), divider state
//   and output valid, and loads the register defaults.
// Stall: a held result stays in the output register; the divider holds its
//   finished results, then the queue fills and in_ready drops.
module color_blob_centroid_tracker_unit #(
	parameter int MAX_ROWS = cbct_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = cbct_pkg::MAX_COLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cbct_pkg::ADDR_W-1:0] paddr,
	input  logic [cbct_pkg::DATA_W-1:0] pwdata,
	output logic [cbct_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cbct_pkg::pix_in_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cbct_pkg::result_t           out_data
);
	import cbct_pkg::*;

	cfg_t      cfg_q;
	reg_idx_t  reg_idx;
	logic      wr_en;
	logic [CH_W-1:0] rd_val;
	logic      q_valid;
	logic      q_ready;
	qent_t     q_data;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_red        <= HEAD_RED_RST;
			cfg_q.head_green      <= HEAD_GREEN_RST;
			cfg_q.head_blue       <= HEAD_BLUE_RST;
			cfg_q.tail_red        <= TAIL_RED_RST;
			cfg_q.tail_green      <= TAIL_GREEN_RST;
			cfg_q.tail_blue       <= TAIL_BLUE_RST;
			cfg_q.color_tolerance <= TOL_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEAD_RED:   cfg_q.head_red        <= pwdata[CH_W-1:0];
				REG_HEAD_GREEN: cfg_q.head_green      <= pwdata[CH_W-1:0];
				REG_HEAD_BLUE:  cfg_q.head_blue       <= pwdata[CH_W-1:0];
				REG_TAIL_RED:   cfg_q.tail_red        <= pwdata[CH_W-1:0];
				REG_TAIL_GREEN: cfg_q.tail_green      <= pwdata[CH_W-1:0];
				REG_TAIL_BLUE:  cfg_q.tail_blue       <= pwdata[CH_W-1:0];
				REG_TOL:        cfg_q.color_tolerance <= pwdata[CH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HEAD_RED:   rd_val = cfg_q.head_red;
			REG_HEAD_GREEN: rd_val = cfg_q.head_green;
			REG_HEAD_BLUE:  rd_val = cfg_q.head_blue;
			REG_TAIL_RED:   rd_val = cfg_q.tail_red;
			REG_TAIL_GREEN: rd_val = cfg_q.tail_green;
			REG_TAIL_BLUE:  rd_val = cfg_q.tail_blue;
			REG_TOL:        rd_val = cfg_q.color_tolerance;
			default:        rd_val = '0;
		endcase
	end

	assign prdata = DATA_W'(rd_val);

	cbct_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data)
	);

	cbct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== sim/color_blob_centroid_tracker_unit_test.sv =====
// Self-checking testbench for color_blob_centroid_tracker_unit: pixel stream, APB setup, centroids.
module color_blob_centroid_tracker_unit_test;
	import cbct_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 4;
	localparam int IDLE_MAX       = 3;
	localparam int DRAIN_CYCLES   = 160;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 40;
	localparam int BURST_ENDS     = 6;
	localparam int REG_SPARE      = 7;
	localparam int FRAME_ROWS     = MAX_ROWS_DEF;
	localparam int FRAME_COLS     = MAX_COLS_DEF;
	localparam int POS_TOP        = (1 << POS_W) - 1;
	localparam int CH_TOP         = (1 << CH_W) - 1;
	localparam logic [HITS_W-1:0] COUNT_SAT = '1;

	typedef enum int {PICK_NEAR, PICK_EDGE, PICK_ANY} pick_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	pix_in_t           in_data  = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	result_t           out_data;

	// stimulus and scoreboard
	pix_in_t     pix_pending[$];
	result_t     centroid_expect[$];
	result_t     centroid_want;
	int          pix_wait       = 0;
	int          res_wait       = 0;
	int unsigned res_draw;
	int          hold_left      = 0;
	logic        stall_arm      = 1'b0;
	logic        stall_taken    = 1'b0;
	logic        calm           = 1'b0;
	int          quiet_cycles   = 0;
	int          fail_count     = 0;
	int          pix_sent       = 0;
	int          frames_checked = 0;
	int          settings_used  = 1;

	// mirror of the register file and the accumulators
	cfg_t              box_cfg   = '{head_red: HEAD_RED_RST, head_green: HEAD_GREEN_RST,
		head_blue: HEAD_BLUE_RST, tail_red: TAIL_RED_RST, tail_green: TAIL_GREEN_RST,
		tail_blue: TAIL_BLUE_RST, color_tolerance: TOL_RST};
	logic [SUM_W-1:0]  head_rsum = '0;
	logic [SUM_W-1:0]  head_csum = '0;
	logic [HITS_W-1:0] head_cnt  = HITS_W'(1);
	logic [SUM_W-1:0]  tail_rsum = '0;
	logic [SUM_W-1:0]  tail_csum = '0;
	logic [HITS_W-1:0] tail_cnt  = HITS_W'(1);

	color_blob_centroid_tracker_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic int unsigned idle_draw();
		if (calm) begin
			return 0;
		end
		return $urandom_range(0, IDLE_MAX);
	endfunction

	// strict on both sides, edges may fall outside 0..255
	function automatic logic chan_near(int c, int t, int tol);
		return c > t - tol && c < t + tol;
	endfunction

	function automatic logic box_hit(pix_in_t p, logic [CH_W-1:0] tr, logic [CH_W-1:0] tg,
		logic [CH_W-1:0] tb);
		int tol;
		tol = box_cfg.color_tolerance;
		return chan_near(p.pix_red, tr, tol) && chan_near(p.pix_green, tg, tol) &&
			chan_near(p.pix_blue, tb, tol);
	endfunction

	function automatic logic [POS_W-1:0] mean_pos(logic [SUM_W-1:0] s, logic [HITS_W-1:0] n);
		logic [SUM_W-1:0] q;
		q = s / ((n == '0) ? HITS_W'(1) : n);
		if (q > POS_TOP) begin
			return POS_W'(POS_TOP);
		end
		return q[POS_W-1:0];
	endfunction

	function automatic void track_pixel(pix_in_t p);
		int      r;
		int      c;
		result_t res;
		r = p.pix_row;
		c = p.pix_col;
		if (r >= FRAME_ROWS) r = FRAME_ROWS - 1;
		if (c >= FRAME_COLS) c = FRAME_COLS - 1;
		if (box_hit(p, box_cfg.head_red, box_cfg.head_green, box_cfg.head_blue)) begin
			head_rsum = head_rsum + SUM_W'(r);
			head_csum = head_csum + SUM_W'(c);
			if (head_cnt != COUNT_SAT) head_cnt = head_cnt + 1'b1;
		end
		if (box_hit(p, box_cfg.tail_red, box_cfg.tail_green, box_cfg.tail_blue)) begin
			tail_rsum = tail_rsum + SUM_W'(r);
			tail_csum = tail_csum + SUM_W'(c);
			if (tail_cnt != COUNT_SAT) tail_cnt = tail_cnt + 1'b1;
		end
		if (p.frame_end) begin
			res.head_row = mean_pos(head_rsum, head_cnt);
			res.head_col = mean_pos(head_csum, head_cnt);
			res.tail_row = mean_pos(tail_rsum, tail_cnt);
			res.tail_col = mean_pos(tail_csum, tail_cnt);
			res.mid_row  = POS_W'(({1'b0, res.head_row} + {1'b0, res.tail_row}) >> 1);
			res.mid_col  = POS_W'(({1'b0, res.head_col} + {1'b0, res.tail_col}) >> 1);
			centroid_expect.insert(centroid_expect.size(), res);
			head_rsum = '0;
			head_csum = '0;
			head_cnt  = HITS_W'(1);
			tail_rsum = '0;
			tail_csum = '0;
			tail_cnt  = HITS_W'(1);
		end
	endfunction

	function automatic void check_field(string name, logic [POS_W-1:0] want,
		logic [POS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void set_reg(int idx, logic [CH_W-1:0] v);
		case (idx)
			REG_HEAD_RED: begin
				box_cfg.head_red = v;
			end
			REG_HEAD_GREEN: begin
				box_cfg.head_green = v;
			end
			REG_HEAD_BLUE: begin
				box_cfg.head_blue = v;
			end
			REG_TAIL_RED: begin
				box_cfg.tail_red = v;
			end
			REG_TAIL_GREEN: begin
				box_cfg.tail_green = v;
			end
			REG_TAIL_BLUE: begin
				box_cfg.tail_blue = v;
			end
			REG_TOL: begin
				box_cfg.color_tolerance = v;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [CH_W-1:0] reg_value(int idx);
		case (idx)
			REG_HEAD_RED:   return box_cfg.head_red;
			REG_HEAD_GREEN: return box_cfg.head_green;
			REG_HEAD_BLUE:  return box_cfg.head_blue;
			REG_TAIL_RED:   return box_cfg.tail_red;
			REG_TAIL_GREEN: return box_cfg.tail_green;
			REG_TAIL_BLUE:  return box_cfg.tail_blue;
			default:        return box_cfg.color_tolerance;
		endcase
	endfunction

	function automatic logic [CH_W-1:0] chan_pick(logic [CH_W-1:0] t, pick_t mode);
		int v;
		int tol;
		tol = box_cfg.color_tolerance;
		case (mode)
			PICK_NEAR: begin
				if (tol == 0) begin
					v = t;
				end else begin
					v = int'(t) + int'($urandom_range(0, 2 * (tol - 1))) - (tol - 1);
				end
			end
			PICK_EDGE: begin
				v = $urandom_range(0, 1) ? int'(t) + tol : int'(t) - tol;
			end
			default: begin
				v = $urandom_range(0, CH_TOP);
			end
		endcase
		if (v < 0) v = 0;
		if (v > CH_TOP) v = CH_TOP;
		return CH_W'(v);
	endfunction

	function automatic logic [POS_W-1:0] pos_pick();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0) return '0;
		if (sel == 1) return '1;
		return POS_W'($urandom_range(0, POS_TOP));
	endfunction

	function automatic pix_in_t gen_pixel();
		pix_in_t         p;
		int              kind;
		int              edge_ch;
		logic            use_head;
		logic [CH_W-1:0] tr;
		logic [CH_W-1:0] tg;
		logic [CH_W-1:0] tb;
		kind     = $urandom_range(0, 9);
		use_head = (kind <= 2) || (kind == 6 && $urandom_range(0, 1) == 1);
		edge_ch  = (kind == 6) ? $urandom_range(0, 2) : 3;
		tr = use_head ? box_cfg.head_red : box_cfg.tail_red;
		tg = use_head ? box_cfg.head_green : box_cfg.tail_green;
		tb = use_head ? box_cfg.head_blue : box_cfg.tail_blue;
		if (kind <= 6) begin
			p.pix_red   = chan_pick(tr, (edge_ch == 0) ? PICK_EDGE : PICK_NEAR);
			p.pix_green = chan_pick(tg, (edge_ch == 1) ? PICK_EDGE : PICK_NEAR);
			p.pix_blue  = chan_pick(tb, (edge_ch == 2) ? PICK_EDGE : PICK_NEAR);
		end else if (kind == 7) begin
			p.pix_red   = $urandom_range(0, 1) ? '1 : '0;
			p.pix_green = $urandom_range(0, 1) ? '1 : '0;
			p.pix_blue  = $urandom_range(0, 1) ? '1 : '0;
		end else begin
			p.pix_red   = chan_pick(tr, PICK_ANY);
			p.pix_green = chan_pick(tg, PICK_ANY);
			p.pix_blue  = chan_pick(tb, PICK_ANY);
		end
		p.pix_row   = pos_pick();
		p.pix_col   = pos_pick();
		p.frame_end = 1'b0;
		return p;
	endfunction

	task automatic push_pixel(int b, int g, int r, int row, int col, logic last);
		pix_in_t p;
		p.pix_blue  = CH_W'(b);
		p.pix_green = CH_W'(g);
		p.pix_red   = CH_W'(r);
		p.pix_row   = POS_W'(row);
		p.pix_col   = POS_W'(col);
		p.frame_end = last;
		pix_pending.insert(pix_pending.size(), p);
		pix_sent++;
	endtask

	// whole frames, mostly short, now and then a long one
	task automatic random_frames(int budget, int max_len);
		int      start;
		int      len;
		pix_in_t p;
		start = pix_sent;
		while (pix_sent - start < budget) begin
			len = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 130) :
				$urandom_range(1, max_len);
			for (int k = 0; k < len; k++) begin
				p = gen_pixel();
				p.frame_end = (k == len - 1);
				pix_pending.insert(pix_pending.size(), p);
				pix_sent++;
			end
		end
	endtask

	task automatic wait_idle();
		while (pix_pending.size() != 0 || in_valid || centroid_expect.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(int idx, logic [CH_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 4);
		pwdata  <= ($urandom() & ~DATA_W'(CH_TOP)) | DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		set_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_read(int idx);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[CH_W-1:0] !== reg_value(idx)) begin
			$error("register %0d: expected %0d, got %0d", idx, reg_value(idx),
				prdata[CH_W-1:0]);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_boxes(int hr, int hg, int hb, int tr, int tg, int tb, int tol);
		reg_write(REG_HEAD_RED, CH_W'(hr));
		reg_write(REG_HEAD_GREEN, CH_W'(hg));
		reg_write(REG_HEAD_BLUE, CH_W'(hb));
		reg_write(REG_TAIL_RED, CH_W'(tr));
		reg_write(REG_TAIL_GREEN, CH_W'(tg));
		reg_write(REG_TAIL_BLUE, CH_W'(tb));
		reg_write(REG_TOL, CH_W'(tol));
		for (int i = REG_HEAD_RED; i <= REG_TOL; i++) begin
			reg_read(i);
		end
		settings_used++;
	endtask

	// pixel request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			pix_wait <= 0;
		end else if (in_valid && !in_ready) begin
			// hold the request until taken
		end else if (pix_wait != 0) begin
			in_valid <= 1'b0;
			pix_wait <= pix_wait - 1;
		end else if (pix_pending.size() != 0) begin
			in_valid <= 1'b1;
			in_data  <= pix_pending.pop_front();
			pix_wait <= idle_draw();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result receiver, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready   <= 1'b0;
			res_wait    <= 0;
			hold_left   <= 0;
			stall_taken <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (stall_arm && !stall_taken) begin
			stall_taken <= 1'b1;
			hold_left   <= HOLD_CYCLES;
			out_ready   <= 1'b0;
		end else if (out_valid && out_ready) begin
			res_draw = idle_draw();
			res_wait  <= res_draw;
			out_ready <= (res_draw == 0);
		end else if (res_wait != 0) begin
			res_wait  <= res_wait - 1;
			out_ready <= (res_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: check results first, then fold in the accepted pixel
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (centroid_expect.size() == 0) begin
					$error("result request with no frame pending");
					fail_count++;
				end else begin
					centroid_want = centroid_expect.pop_front();
					check_field("head_row", centroid_want.head_row, out_data.head_row);
					check_field("head_col", centroid_want.head_col, out_data.head_col);
					check_field("tail_row", centroid_want.tail_row, out_data.tail_row);
					check_field("tail_col", centroid_want.tail_col, out_data.tail_col);
					check_field("mid_row", centroid_want.mid_row, out_data.mid_row);
					check_field("mid_col", centroid_want.mid_col, out_data.mid_col);
					frames_checked++;
				end
			end
			if (in_valid && in_ready) begin
				track_pixel(in_data);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: exact targets, box edges, index extremes, empty frames
		push_pixel(box_cfg.head_blue, box_cfg.head_green, box_cfg.head_red, 0, 0, 1'b0);
		push_pixel(box_cfg.tail_blue, box_cfg.tail_green, box_cfg.tail_red, POS_TOP, POS_TOP,
			1'b0);
		push_pixel(0, 0, 0, POS_TOP, 0, 1'b0);
		push_pixel(CH_TOP, CH_TOP, CH_TOP, 0, POS_TOP, 1'b0);
		push_pixel(box_cfg.head_blue + box_cfg.color_tolerance, box_cfg.head_green,
			box_cfg.head_red, 5, 5, 1'b0);
		push_pixel(box_cfg.head_blue - box_cfg.color_tolerance, box_cfg.head_green,
			box_cfg.head_red, 6, 6, 1'b0);
		push_pixel(box_cfg.head_blue + box_cfg.color_tolerance - 1, box_cfg.head_green,
			box_cfg.head_red, 700, 300, 1'b0);
		push_pixel(box_cfg.tail_blue, box_cfg.tail_green,
			box_cfg.tail_red - box_cfg.color_tolerance + 1, POS_TOP, POS_TOP, 1'b1);
		push_pixel(0, 0, 0, 0, 0, 1'b1);
		push_pixel(box_cfg.head_blue, box_cfg.head_green, box_cfg.head_red, POS_TOP, POS_TOP,
			1'b1);
		// back-to-back frame ends queue up behind the divider
		push_pixel(box_cfg.head_blue, box_cfg.head_green, box_cfg.head_red, 17, 900, 1'b1);
		push_pixel(box_cfg.tail_blue, box_cfg.tail_green, box_cfg.tail_red, 900, 17, 1'b1);
		push_pixel(CH_TOP, 0, CH_TOP, 333, 444, 1'b1);
		push_pixel(box_cfg.tail_blue, box_cfg.tail_green, box_cfg.tail_red, POS_TOP, POS_TOP,
			1'b0);
		push_pixel(box_cfg.tail_blue, box_cfg.tail_green, box_cfg.tail_red, POS_TOP, POS_TOP,
			1'b0);
		push_pixel(box_cfg.head_blue, box_cfg.head_green, box_cfg.head_red, POS_TOP, POS_TOP,
			1'b1);
		random_frames(PHASE_ITEMS, 12);
		wait_idle();

		// random boxes, stray write past the register list, no idling
		load_boxes($urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP),
			$urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP),
			$urandom_range(0, CH_TOP), $urandom_range(20, 80));
		reg_write(REG_SPARE, CH_W'($urandom_range(0, CH_TOP)));
		for (int i = REG_HEAD_RED; i <= REG_TOL; i++) begin
			reg_read(i);
		end
		calm = 1'b1;
		random_frames(PHASE_ITEMS, 12);
		wait_idle();
		calm = 1'b0;

		// widest boxes at the channel extremes
		load_boxes(0, 0, 0, CH_TOP, CH_TOP, CH_TOP, CH_TOP);
		random_frames(PHASE_ITEMS, 12);
		wait_idle();

		// zero tolerance: nothing matches
		load_boxes($urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP),
			$urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP),
			$urandom_range(0, CH_TOP), 0);
		random_frames(PHASE_ITEMS, 12);
		wait_idle();

		// tolerance one: only the exact target matches
		load_boxes(CH_TOP, CH_TOP, CH_TOP, 0, 0, 0, 1);
		random_frames(PHASE_ITEMS, 12);
		wait_idle();

		// long output stall while pixels keep coming; a burst of frame ends fills the queue
		load_boxes($urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP),
			$urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP),
			$urandom_range(0, CH_TOP), $urandom_range(1, CH_TOP));
		stall_arm <= 1'b1;
		for (int k = 0; k < BURST_ENDS; k++) begin
			push_pixel(k, k, k, k, k, 1'b1);
		end
		random_frames(PHASE_ITEMS, 40);
		wait_idle();

		load_boxes($urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP),
			$urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP),
			$urandom_range(0, CH_TOP), $urandom_range(10, 120));
		random_frames(PHASE_ITEMS, 12);
		wait_idle();

		if (centroid_expect.size() != 0) begin
			$error("%0d frame results never arrived", centroid_expect.size());
			fail_count++;
		end
		$display("Sent %0d pixel requests under %0d box settings, with one long output stall.",
			pix_sent, settings_used);
		$display("Compared %0d frame centroid results; %0d mismatches.", frames_checked,
			fail_count);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
